// ----- rtl/fat12_pkg.sv -----
package fat12_pkg;

  typedef logic [2:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [11:0] link_t;

  // Operation codes carried on the input channel.
  localparam kind_t K_RD_ENTRY = 3'd0;
  localparam kind_t K_WR_ENTRY = 3'd1;
  localparam kind_t K_FIND     = 3'd2;
  localparam kind_t K_FREE     = 3'd3;
  localparam kind_t K_WR_BYTE  = 3'd4;
  localparam kind_t K_RD_BYTE  = 3'd5;

  // Result status codes.
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_RANGE  = 2'd1;
  localparam status_t ST_NOFREE = 2'd2;

  // Links at or above this value mark the end of a chain.
  localparam link_t CHAIN_END = 12'hFF8;

  localparam int          TABLE_BYTES_DEF = 1024;
  localparam logic [9:0]  LIMIT_RESET     = 10'd356;

endpackage

// ----- rtl/fat12_cluster_table_engine.sv -----
// FAT12 allocation table engine.
// The block holds a FAT12 table as a byte memory, with 12-bit entries packed
// two to three bytes, and serves one operation per input transfer: read entry,
// write entry, find the next free entry, free a chain, write a byte, read a
// byte. Every input transfer produces exactly one result transfer carrying a
// 12-bit value and a 2-bit status.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. The block raises in_stall from the cycle after an
// accepted transfer until the result has been moved into the output register.
// Entry operations check the range, then read the low and high bytes; entry
// writes then rewrite both bytes. Find free tests one cluster after another
// and free chain clears one link after another. A new input transfer can
// be accepted, at the earliest, in the cycle after the result enters the
// output register. The user must write the cluster_limit register through
// cfg_we and cfg_wdata only while the block is idle, which the block does
// not enforce.
// A synchronous active-low reset empties the output register, returns the
// sequencer to idle and sets cluster_limit to 356; table contents are left
// undefined until written. When the receiver stalls, the result holds in the
// output register and a finished result waits in the finish state.
module fat12_cluster_table_engine
  import fat12_pkg::*;
#(
  parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [11:0] in_cluster,
  input  logic [11:0] in_entry_value,
  input  logic [9:0]  in_byte_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_result_value,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_BYTES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;  // range check, offset computation
  localparam logic [2:0] S_RA   = 3'd2;  // read low byte
  localparam logic [2:0] S_RB   = 3'd3;  // read high byte, capture low
  localparam logic [2:0] S_RC   = 3'd4;  // entry available, write low byte
  localparam logic [2:0] S_WB   = 3'd5;  // write high byte
  localparam logic [2:0] S_BR   = 3'd6;  // byte read data available
  localparam logic [2:0] S_FIN  = 3'd7;  // hand result to output register

  logic [2:0]    state_r, state_nxt;
  kind_t         kind_r, kind_nxt;
  logic [12:0]   c_r, c_nxt;            // cluster cursor of the current walk
  link_t         val_r, val_nxt;
  logic [11:0]   n_r, n_nxt;            // clusters freed so far
  logic [AW-1:0] off_r, off_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic [7:0]    hi_r, hi_nxt;
  link_t         res_r, res_nxt;
  status_t       st_r, st_nxt;
  logic [9:0]    limit_r;
  logic          out_valid_r, out_valid_nxt;
  link_t         out_res_r, out_res_nxt;
  status_t       out_st_r, out_st_nxt;

  // Table memory, one write and one registered read per cycle.
  logic [7:0]    mem [TABLE_BYTES];
  logic [7:0]    mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] mem_ra;

  // Shared offset and range unit: offset = c*3/2, valid when c is below cluster_limit and the entry fits.
  logic [13:0] off_w;
  logic [14:0] off_p1;
  logic        c_ok;
  logic        addr_ok;
  logic [15:0] word_w;
  link_t       entry_w;
  link_t       new_link;
  logic [15:0] new_word;

  assign off_w   = {1'b0, c_r} + {2'b00, c_r[12:1]};
  assign off_p1  = {1'b0, off_w} + 15'd1;
  assign c_ok    = (c_r < {3'b000, limit_r}) && (off_p1 < 15'(TABLE_BYTES));
  assign addr_ok = {5'b00000, in_byte_addr} < 15'(TABLE_BYTES);

  assign word_w   = {mem_q_r, lo_r};
  assign entry_w  = c_r[0] ? word_w[15:4] : word_w[11:0];
  assign new_link = (kind_r == K_FREE) ? 12'h000 : val_r;
  assign new_word = c_r[0] ? {new_link, word_w[3:0]} : {word_w[15:12], new_link};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    c_nxt         = c_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    off_nxt       = off_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = off_r;
    mem_wd        = lo_r;
    mem_ra        = off_r;

    case (state_r)
      S_IDLE: begin
        mem_ra = AW'(in_byte_addr);
        if (in_valid) begin
          kind_nxt = in_kind;
          c_nxt    = {1'b0, in_cluster};
          val_nxt  = in_entry_value;
          n_nxt    = 12'd0;
          res_nxt  = 12'd0;
          st_nxt   = ST_OK;
          case (in_kind)
            K_RD_ENTRY, K_WR_ENTRY: begin
              state_nxt = S_CHK;
            end
            K_FIND: begin
              c_nxt     = {1'b0, in_cluster} + 13'd1;
              state_nxt = S_CHK;
            end
            K_FREE: begin
              state_nxt = (in_cluster == 12'd0) ? S_FIN : S_CHK;
            end
            K_WR_BYTE: begin
              if (addr_ok) begin
                mem_we = 1'b1;
                mem_wa = AW'(in_byte_addr);
                mem_wd = in_entry_value[7:0];
              end else begin
                st_nxt = ST_RANGE;
              end
              state_nxt = S_FIN;
            end
            K_RD_BYTE: begin
              if (addr_ok) begin
                state_nxt = S_BR;
              end else begin
                st_nxt    = ST_RANGE;
                state_nxt = S_FIN;
              end
            end
            default: begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_CHK: begin
        off_nxt = AW'(off_w);
        case (kind_r)
          K_FIND: begin
            if (c_ok) begin
              state_nxt = S_RA;
            end else begin
              st_nxt    = ST_NOFREE;
              state_nxt = S_FIN;
            end
          end
          K_FREE: begin
            res_nxt = n_r;
            if (c_r >= {1'b0, CHAIN_END}) begin
              state_nxt = S_FIN;
            end else if (c_r < 13'd2 || !c_ok) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RA;
            end
          end
          default: begin
            if (c_ok) begin
              state_nxt = S_RA;
            end else begin
              st_nxt    = ST_RANGE;
              state_nxt = S_FIN;
            end
          end
        endcase
      end

      S_RA: begin
        mem_ra    = off_r;
        state_nxt = S_RB;
      end

      S_RB: begin
        mem_ra    = off_r + AW'(1);
        lo_nxt    = mem_q_r;
        state_nxt = S_RC;
      end

      S_RC: begin
        case (kind_r)
          K_RD_ENTRY: begin
            res_nxt   = entry_w;
            state_nxt = S_FIN;
          end
          K_FIND: begin
            if (entry_w == 12'd0) begin
              res_nxt   = c_r[11:0];
              state_nxt = S_FIN;
            end else begin
              c_nxt     = c_r + 13'd1;
              state_nxt = S_CHK;
            end
          end
          default: begin
            // Write entry and free chain both rewrite the packed word here.
            mem_we    = 1'b1;
            mem_wa    = off_r;
            mem_wd    = new_word[7:0];
            hi_nxt    = new_word[15:8];
            if (kind_r == K_FREE) begin
              c_nxt = {1'b0, entry_w};
              n_nxt = n_r + 12'd1;
            end
            state_nxt = S_WB;
          end
        endcase
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_wa    = off_r + AW'(1);
        mem_wd    = hi_r;
        state_nxt = (kind_r == K_FREE) ? S_CHK : S_FIN;
      end

      S_BR: begin
        res_nxt   = {4'h0, mem_q_r};
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    c_r       <= c_nxt;
    val_r     <= val_nxt;
    n_r       <= n_nxt;
    off_r     <= off_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;

endmodule

// ----- rtl/fat12_checker.sv -----
module fat12_checker
  import fat12_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_result_value,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_value) && $stable(out_status))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the operation finished");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFREE |-> out_result_value == 12'd0)
    else $error("failed search returned a nonzero value");

endmodule

bind fat12_cluster_table_engine fat12_checker u_fat12_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);

// ----- verif/fat12_cluster_table_engine_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the FAT12 cluster table engine.
// The table is first loaded byte by byte, so that no entry is ever read
// before it has been written. A short directed list then covers the
// special cases. Random phases follow, each under its own cluster_limit
// setting. A shadow copy of the table predicts every result in the order
// the input transfers are accepted. The receiver checks each result
// transfer against the oldest prediction.
module fat12_cluster_table_engine_test;
  import fat12_pkg::*;

  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int HOLD_CYCLES      = 200;
  localparam int DRAIN_CYCLES     = 64;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int PHASES           = 5;
  localparam int MAX_PRINTED      = 100;

  // Highest cluster count whose entries still fit in the byte store.
  localparam int CLUSTER_SPAN = (TABLE_BYTES_DEF * 2) / 3;

  // Kinds 6 and 7 have no operation behind them and must answer with an error.
  localparam kind_t K_UNUSED_LO = 3'd6;
  localparam kind_t K_UNUSED_HI = 3'd7;

  // Clusters from this value upward are reserved and never addressable.
  localparam link_t FIRST_RESERVED = 12'hFF7;
  localparam link_t LAST_LINK      = 12'hFFF;

  typedef struct packed {
    kind_t   kind;
    link_t   value;
    status_t status;
  } table_answer_t;

  // Shadow of the allocation table. It applies each accepted operation to
  // its own copy of the store and queues the answer the block must give.
  class fat_shadow_table;
    logic [7:0]    table_image [TABLE_BYTES_DEF];
    link_t         walk_cursor;
    link_t         walk_count;
    logic [9:0]    limit;
    table_answer_t awaited[$];
    int            kind_count [8];
    int            checked;
    int            mismatches;

    function new();
      foreach (table_image[i]) table_image[i] = 8'h00;
      foreach (kind_count[i]) kind_count[i] = 0;
      walk_cursor = '0;
      walk_count  = '0;
      limit       = LIMIT_RESET;
      checked     = 0;
      mismatches  = 0;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function bit is_valid(int c);
      return c < int'(limit) && c < int'(FIRST_RESERVED) && (c * 3) / 2 + 1 < TABLE_BYTES_DEF;
    endfunction

    function link_t entry_at(int c);
      int          off;
      logic [15:0] w;
      off = (c * 3) / 2;
      w   = {table_image[off + 1], table_image[off]};
      return c[0] ? w[15:4] : w[11:0];
    endfunction

    function void store_entry(int c, link_t v);
      int          off;
      logic [15:0] w;
      off = (c * 3) / 2;
      w   = {table_image[off + 1], table_image[off]};
      // The neighbor's nibble in the shared byte is kept.
      if (c[0]) w = {v, w[3:0]};
      else      w = {w[15:12], v};
      table_image[off]     = w[7:0];
      table_image[off + 1] = w[15:8];
    endfunction

    function void note_op(kind_t k, link_t cl, link_t v, logic [9:0] a);
      table_answer_t ans;
      int            c;
      int            freed;
      link_t         nx;
      ans.kind   = k;
      ans.value  = '0;
      ans.status = ST_OK;
      kind_count[k]++;
      case (k)
        K_RD_ENTRY: begin
          if (is_valid(cl)) ans.value = entry_at(cl);
          else ans.status = ST_RANGE;
        end
        K_WR_ENTRY: begin
          if (is_valid(cl)) store_entry(cl, v);
          else ans.status = ST_RANGE;
        end
        K_FIND: begin
          ans.status = ST_NOFREE;
          c = int'(cl) + 1;
          while (is_valid(c)) begin
            walk_cursor = link_t'(c);
            if (entry_at(c) == '0) begin
              ans.value  = link_t'(c);
              ans.status = ST_OK;
              break;
            end
            c++;
          end
        end
        K_FREE: begin
          // A chain ends at an end marker; a link to a cluster below 2 or out
          // of range breaks it. Every step clears an entry, so loops end too.
          c     = int'(cl);
          freed = 0;
          if (c != 0) begin
            while (c < int'(CHAIN_END)) begin
              walk_cursor = link_t'(c);
              if (c < 2 || !is_valid(c)) begin
                ans.status = ST_RANGE;
                break;
              end
              nx = entry_at(c);
              store_entry(c, '0);
              freed++;
              c = int'(nx);
            end
          end
          walk_count = link_t'(freed);
          ans.value  = link_t'(freed);
        end
        K_WR_BYTE: begin
          if (int'(a) < TABLE_BYTES_DEF) table_image[a] = v[7:0];
          else ans.status = ST_RANGE;
        end
        K_RD_BYTE: begin
          if (int'(a) < TABLE_BYTES_DEF) ans.value = {4'h0, table_image[a]};
          else ans.status = ST_RANGE;
        end
        default: ans.status = ST_RANGE;
      endcase
      awaited.push_back(ans);
    endfunction

    function void check_result(link_t v, status_t st);
      table_answer_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result %03h status %0d with nothing awaited", v, st));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (v !== want.value)
        report($sformatf("result %0d (kind %0d): value %03h, expected %03h",
                         checked, want.kind, v, want.value));
      if (st !== want.status)
        report($sformatf("result %0d (kind %0d): status %0d, expected %0d",
                         checked, want.kind, st, want.status));
    endfunction

    function void check_drained();
      if (awaited.size() != 0)
        report($sformatf("%0d results never arrived", awaited.size()));
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind        = '0;
  logic [11:0] in_cluster     = '0;
  logic [11:0] in_entry_value = '0;
  logic [9:0]  in_byte_addr   = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [11:0] out_result_value;
  logic [1:0]  out_status;
  logic        cfg_we         = 1'b0;
  logic [9:0]  cfg_wdata      = '0;

  fat_shadow_table table_shadow = new();

  int cycle_count   = 0;
  int ops_sent      = 0;
  int settings_used = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;
  bit no_gaps       = 1'b0;

  fat12_cluster_table_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_cluster      (in_cluster),
    .in_entry_value  (in_entry_value),
    .in_byte_addr    (in_byte_addr),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_value(out_result_value),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #4 clk = ~clk;

  // The run is cut off well beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, table_shadow.awaited.size());
      $display("fat12_cluster_table_engine_test failed");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the clock edge, so the values seen
  // here are the ones the block presented during the cycle just ended. Stall
  // is random, low in the gap-free phase, but for one long hold-off that lets
  // the block fill up and push back on its input while the sender offers.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) table_shadow.check_result(out_result_value, out_status);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < 24);
      end
    end
  end

  // Offers one operation and returns once its input transfer has happened.
  // Random idle cycles go before the offer; the payload stays put while the
  // block stalls.
  task automatic send_op(input kind_t k, input link_t cl, input link_t v,
                         input logic [9:0] a);
    while (!no_gaps && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_cluster     <= cl;
    in_entry_value <= v;
    in_byte_addr   <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_shadow.note_op(k, cl, v, a);
    ops_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (table_shadow.awaited.size() != 0) @(posedge clk);
  endtask

  // The limit register is only written with nothing in flight.
  task automatic set_limit(input logic [9:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_shadow.limit = value;
    settings_used++;
  endtask

  function automatic int usable_clusters();
    return (int'(table_shadow.limit) < CLUSTER_SPAN) ? int'(table_shadow.limit) : CLUSTER_SPAN;
  endfunction

  // Mostly an addressable cluster, sometimes any 12-bit value.
  function automatic link_t pick_cluster();
    int span;
    span = usable_clusters();
    if (span == 0 || $urandom_range(9) == 0) return link_t'($urandom_range(4095));
    return link_t'($urandom_range(span - 1, 0));
  endfunction

  // Entry content: free, a link to a live cluster, an end marker, or noise.
  function automatic link_t pick_link();
    int span;
    int roll;
    span = usable_clusters();
    roll = $urandom_range(99);
    if (roll < 25) return '0;
    if (roll < 70 && span > 2) return link_t'($urandom_range(span - 1, 2));
    if (roll < 90) return CHAIN_END + link_t'($urandom_range(7));
    return link_t'($urandom_range(4095));
  endfunction

  // Packs random entries into all but the last byte of the store, which gets
  // noise, so that chains, free entries and end markers exist from the start.
  task automatic load_table();
    link_t lo;
    link_t hi;
    int    k;
    for (k = 0; k < CLUSTER_SPAN / 2; k++) begin
      lo = pick_link();
      hi = pick_link();
      send_op(K_WR_BYTE, pick_cluster(), {4'($urandom_range(15)), lo[7:0]}, 10'(3 * k));
      send_op(K_WR_BYTE, pick_cluster(), {4'($urandom_range(15)), hi[3:0], lo[11:8]},
              10'(3 * k + 1));
      send_op(K_WR_BYTE, pick_cluster(), {4'($urandom_range(15)), hi[11:4]},
              10'(3 * k + 2));
    end
    for (k = 3 * (CLUSTER_SPAN / 2); k < TABLE_BYTES_DEF; k++)
      send_op(K_WR_BYTE, pick_cluster(), link_t'($urandom_range(4095)), 10'(k));
  endtask

  // Special cases under the reset value of cluster_limit.
  task automatic run_directed();
    link_t top;
    top = link_t'(LIMIT_RESET) - 12'd1;
    // Two neighbors share the middle byte; each write keeps the other's nibble.
    send_op(K_WR_ENTRY, 12'd40, 12'hABC, 10'h3FF);
    send_op(K_WR_ENTRY, 12'd41, 12'h123, 10'h000);
    send_op(K_RD_BYTE, 12'd0, 12'd0, 10'd60);
    send_op(K_RD_BYTE, 12'd0, 12'd0, 10'd61);
    send_op(K_RD_BYTE, 12'd0, 12'd0, 10'd62);
    send_op(K_RD_ENTRY, 12'd40, 12'd0, 10'd0);
    send_op(K_RD_ENTRY, 12'd41, 12'd0, 10'd0);
    // Lowest and highest addressable clusters, then just past the limit.
    send_op(K_RD_ENTRY, 12'd0, 12'd0, 10'd0);
    send_op(K_RD_ENTRY, top, 12'd0, 10'd0);
    send_op(K_RD_ENTRY, link_t'(LIMIT_RESET), 12'd0, 10'd0);
    send_op(K_RD_ENTRY, LAST_LINK, 12'd0, 10'd0);
    send_op(K_WR_ENTRY, LAST_LINK, LAST_LINK, 10'h3FF);
    // A two-cluster chain closed by an end marker.
    send_op(K_WR_ENTRY, 12'd10, 12'd11, 10'd0);
    send_op(K_WR_ENTRY, 12'd11, LAST_LINK, 10'd0);
    send_op(K_FREE, 12'd10, 12'd0, 10'd0);
    // Chains broken by a link to cluster 1 and by a link out of range.
    send_op(K_WR_ENTRY, 12'd20, 12'd1, 10'd0);
    send_op(K_FREE, 12'd20, 12'd0, 10'd0);
    send_op(K_WR_ENTRY, 12'd30, 12'hF00, 10'd0);
    send_op(K_FREE, 12'd30, 12'd0, 10'd0);
    // Heads that free nothing.
    send_op(K_FREE, 12'd0, 12'd0, 10'd0);
    send_op(K_FREE, CHAIN_END, 12'd0, 10'd0);
    // Searches that find nothing: one tests only the last cluster, the other
    // starts at the last cluster and so tests none.
    send_op(K_WR_ENTRY, top, LAST_LINK, 10'd0);
    send_op(K_FIND, top - 12'd1, 12'd0, 10'd0);
    send_op(K_FIND, top, 12'd0, 10'd0);
    send_op(K_FIND, 12'd0, 12'd0, 10'd0);
    send_op(K_UNUSED_LO, 12'd5, 12'd5, 10'd5);
    send_op(K_UNUSED_HI, LAST_LINK, LAST_LINK, 10'h3FF);
    send_op(K_WR_BYTE, LAST_LINK, LAST_LINK, 10'h3FF);
    send_op(K_RD_BYTE, LAST_LINK, LAST_LINK, 10'h3FF);
  endtask

  // Writes a short chain over distinct clusters, then usually frees it.
  task automatic build_chain();
    link_t members [6];
    int    span;
    int    n;
    int    i;
    int    j;
    bit    taken;
    span = usable_clusters();
    if (span < 8) begin
      send_op(K_FREE, pick_cluster(), link_t'($urandom_range(4095)), 10'($urandom_range(1023)));
      return;
    end
    n = $urandom_range(6, 2);
    for (i = 0; i < n; i++) begin
      taken = 1'b1;
      while (taken) begin
        members[i] = link_t'($urandom_range(span - 1, 2));
        taken = 1'b0;
        for (j = 0; j < i; j++) if (members[j] == members[i]) taken = 1'b1;
      end
    end
    for (i = 0; i < n - 1; i++)
      send_op(K_WR_ENTRY, members[i], members[i + 1], 10'($urandom_range(1023)));
    send_op(K_WR_ENTRY, members[n - 1], CHAIN_END + link_t'($urandom_range(7)),
            10'($urandom_range(1023)));
    if ($urandom_range(9) < 8)
      send_op(K_FREE, members[0], link_t'($urandom_range(4095)), 10'($urandom_range(1023)));
  endtask

  task automatic run_random_phase(input int count);
    int first;
    int roll;
    first = ops_sent;
    while (ops_sent - first < count) begin
      roll = $urandom_range(99);
      if (roll < 18)
        send_op(K_RD_ENTRY, pick_cluster(), link_t'($urandom_range(4095)),
                10'($urandom_range(1023)));
      else if (roll < 34)
        send_op(K_WR_ENTRY, pick_cluster(), pick_link(), 10'($urandom_range(1023)));
      else if (roll < 46)
        send_op(K_FIND, pick_cluster(), link_t'($urandom_range(4095)),
                10'($urandom_range(1023)));
      else if (roll < 56)
        send_op(K_FREE, pick_cluster(), link_t'($urandom_range(4095)),
                10'($urandom_range(1023)));
      else if (roll < 72)
        build_chain();
      else if (roll < 82)
        send_op(K_WR_BYTE, link_t'($urandom_range(4095)), link_t'($urandom_range(4095)),
                10'($urandom_range(1023)));
      else if (roll < 96)
        send_op(K_RD_BYTE, link_t'($urandom_range(4095)), link_t'($urandom_range(4095)),
                10'($urandom_range(1023)));
      else
        send_op($urandom_range(1) ? K_UNUSED_HI : K_UNUSED_LO, link_t'($urandom_range(4095)),
                link_t'($urandom_range(4095)), 10'($urandom_range(1023)));
    end
  endtask

  initial begin
    logic [9:0] phase_limits [PHASES];
    int         p;
    // The store's full span, a limit of two, a value beyond the store's reach,
    // one random setting and a return to the reset value.
    phase_limits[0] = 10'd682;
    phase_limits[1] = 10'd2;
    phase_limits[2] = 10'd1023;
    phase_limits[3] = 10'($urandom_range(682, 2));
    phase_limits[4] = LIMIT_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_table();
    run_directed();

    for (p = 0; p < PHASES; p++) begin
      set_limit(phase_limits[p]);
      // The first phase opens with the long hold-off on the result side;
      // the third runs without any idle cycles on either side.
      if (p == 0) hold_request = 1'b1;
      no_gaps = (p == 2);
      run_random_phase(RANDOM_PER_PHASE);
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    table_shadow.check_drained();

    $display("Sent %0d transfers under %0d limit settings: %0d entry reads, %0d entry writes,",
             ops_sent, settings_used + 1, table_shadow.kind_count[K_RD_ENTRY],
             table_shadow.kind_count[K_WR_ENTRY]);
    $display("%0d searches, %0d chain frees, %0d byte ops, %0d bad kinds; %0d results checked.",
             table_shadow.kind_count[K_FIND], table_shadow.kind_count[K_FREE],
             table_shadow.kind_count[K_WR_BYTE] + table_shadow.kind_count[K_RD_BYTE],
             table_shadow.kind_count[K_UNUSED_LO] + table_shadow.kind_count[K_UNUSED_HI],
             table_shadow.checked);
    if (table_shadow.mismatches == 0) begin
      $display("fat12_cluster_table_engine_test passed");
    end else begin
      $display("fat12_cluster_table_engine_test failed");
    end
    $finish;
  end

endmodule
